### hdl/swl_pkg.sv
// Shared types, constants and helpers for the stop-and-wait packet link.
`default_nettype none
package swl_pkg;

  localparam int PACKET_BYTES = 16;
  localparam int QUEUE_DEPTH  = 8;

  localparam int BYTE_W      = 8;
  localparam int LEVEL_W     = 4;
  localparam int TIMEOUT_W   = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int SLOT_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int BIDX_W      = $clog2(PACKET_BYTES);
  localparam int STORE_DEPTH = QUEUE_DEPTH * PACKET_BYTES;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam logic [BIDX_W-1:0]    LAST_BYTE     = BIDX_W'(PACKET_BYTES - 1);
  localparam logic [FILL_W-1:0]    FILL_FULL     = FILL_W'(QUEUE_DEPTH);
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [TIMEOUT_W-1:0] ELAPSED_MAX   = 16'hFFFF;

  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ID = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STATUS_OK = 2'd2;

  typedef enum logic [1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_RX_BYTE = 2'd1,
    CMD_TICK    = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  typedef enum logic {
    BE_IDLE,
    BE_SEND
  } be_state_t;

  typedef struct packed {
    logic               is_send;
    logic [SLOT_W-1:0]  slot;
    logic               connected;
    logic               pending;
    logic               bad;
    logic               drop;
    logic [LEVEL_W-1:0] level;
  } job_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } store_wr_t;

  function automatic logic [ADDR_W-1:0] slot_addr(input logic [SLOT_W-1:0] slot,
                                                  input logic [BIDX_W-1:0] idx);
    slot_addr = ADDR_W'(slot) * ADDR_W'(PACKET_BYTES) + ADDR_W'(idx);
  endfunction

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] slot);
    next_slot = (slot == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : slot + SLOT_W'(1);
  endfunction

endpackage
`default_nettype wire

### hdl/stop_and_wait_packet_link_top.sv
// Top level of the stop-and-wait packet link.
// Input channel (in_valid/in_ready) carries one request: in_command selects
// enqueue byte, received byte, tick or clear; in_data_byte and in_tx_ready go with it.
// Result channel (out_valid/out_ready) carries result records: a tick that sends
// gives PACKET_BYTES records (checksum in the last, out_tx_last on it), every other
// request gives one record with out_tx_last set.
// cfg_wr_en/cfg_index/cfg_wdata write timeout, device id or OK code, chosen by cfg_index.
// A single-record request passes through the job queue into the result register. A
// sending tick passes the job queue, job pickup and a first store read before its
// first byte, then gives one byte a cycle while the receiver does not stall.
// The front takes one request per cycle while the job queue has room; a send holds the
// back end: job pickup, first store read, then one byte a cycle off the single read port.
// Enqueue requests are held off while a send is queued or streaming.
// Reset (rst_n low, synchronous) empties the queues, clears link state and loads
// default configuration. When the receiver stalls, the result register holds,
// the back end stops, and the front keeps taking requests until the job queue fills.
`default_nettype none
module stop_and_wait_packet_link_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [1:0]                     in_command,
  input  wire logic [swl_pkg::BYTE_W-1:0]     in_data_byte,
  input  wire logic                           in_tx_ready,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_tx_valid,
  output logic      [swl_pkg::BYTE_W-1:0]     out_tx_byte,
  output logic                                out_tx_last,
  output logic                                out_link_connected,
  output logic                                out_reply_pending,
  output logic                                out_rx_bad_checksum,
  output logic                                out_queue_dropped,
  output logic      [swl_pkg::LEVEL_W-1:0]    out_queue_level,
  input  wire logic                           cfg_wr_en,
  input  wire logic [swl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [swl_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  swl_pkg::job_t              push_job, head_job;
  swl_pkg::store_wr_t         store_wr;
  logic                       job_push, job_pop, job_full, job_avail, fifo_has_send;
  logic                       busy_send, send_busy;
  logic [swl_pkg::ADDR_W-1:0] rd_addr;
  logic [swl_pkg::BYTE_W-1:0] rd_data;

  assign send_busy = fifo_has_send || busy_send;

  swl_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_data_byte (in_data_byte),
    .in_tx_ready  (in_tx_ready),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .job_full     (job_full),
    .send_busy    (send_busy),
    .job_push     (job_push),
    .job          (push_job),
    .store_wr     (store_wr)
  );

  swl_job_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (push_job),
    .pop      (job_pop),
    .full     (job_full),
    .avail    (job_avail),
    .head_job (head_job),
    .has_send (fifo_has_send)
  );

  swl_store u_store (
    .clk     (clk),
    .wr      (store_wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  swl_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .job_avail           (job_avail),
    .job_head            (head_job),
    .job_pop             (job_pop),
    .rd_addr             (rd_addr),
    .rd_data             (rd_data),
    .busy_send           (busy_send),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_tx_valid        (out_tx_valid),
    .out_tx_byte         (out_tx_byte),
    .out_tx_last         (out_tx_last),
    .out_link_connected  (out_link_connected),
    .out_reply_pending   (out_reply_pending),
    .out_rx_bad_checksum (out_rx_bad_checksum),
    .out_queue_dropped   (out_queue_dropped),
    .out_queue_level     (out_queue_level)
  );

endmodule
`default_nettype wire

### hdl/swl_store.sv
// Packet byte store: one write port, one registered read port.
`default_nettype none
module swl_store (
  input  wire logic                       clk,
  input  wire swl_pkg::store_wr_t         wr,
  input  wire logic [swl_pkg::ADDR_W-1:0] rd_addr,
  output logic      [swl_pkg::BYTE_W-1:0] rd_data
);

  logic [swl_pkg::BYTE_W-1:0] mem [swl_pkg::STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

### hdl/swl_front.sv
// Front end: accepts requests, updates link state, writes packets, emits jobs.
`default_nettype none
module swl_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [1:0]                     in_command,
  input  wire logic [swl_pkg::BYTE_W-1:0]     in_data_byte,
  input  wire logic                           in_tx_ready,
  input  wire logic                           cfg_wr_en,
  input  wire logic [swl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [swl_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic                           job_full,
  input  wire logic                           send_busy,
  output logic                                job_push,
  output swl_pkg::job_t                       job,
  output swl_pkg::store_wr_t                  store_wr
);

  swl_pkg::cmd_t cmd;
  logic          accept;

  logic [swl_pkg::TIMEOUT_W-1:0] timeout_r;
  logic [swl_pkg::BYTE_W-1:0]    device_id_r, status_ok_r;

  logic [swl_pkg::SLOT_W-1:0]    head_r, head_nxt, tail_r, tail_nxt;
  logic [swl_pkg::FILL_W-1:0]    fill_r, fill_nxt;
  logic [swl_pkg::BIDX_W-1:0]    stage_r, stage_nxt;
  logic                          stage_drop_r, stage_drop_nxt;
  logic                          waiting_r, waiting_nxt, connected_r, connected_nxt;
  logic [swl_pkg::TIMEOUT_W-1:0] elapsed_r, elapsed_nxt, elapsed_inc;
  logic [swl_pkg::BIDX_W-1:0]    rx_count_r, rx_count_nxt;
  logic [swl_pkg::BYTE_W-1:0]    rx_sum_r, rx_sum_nxt;
  logic [swl_pkg::BYTE_W-1:0]    rx_first_r, rx_first_nxt, rx_second_r, rx_second_nxt;
  logic                          bad, drop, is_send, full;

  assign cmd      = swl_pkg::cmd_t'(in_command);
  assign in_ready = !job_full && !(cmd == swl_pkg::CMD_ENQUEUE && send_busy);
  assign accept   = in_valid && in_ready;
  assign full     = (fill_r == swl_pkg::FILL_FULL);

  always_comb begin
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    fill_nxt       = fill_r;
    stage_nxt      = stage_r;
    stage_drop_nxt = stage_drop_r;
    waiting_nxt    = waiting_r;
    connected_nxt  = connected_r;
    elapsed_nxt    = elapsed_r;
    rx_count_nxt   = rx_count_r;
    rx_sum_nxt     = rx_sum_r;
    rx_first_nxt   = rx_first_r;
    rx_second_nxt  = rx_second_r;
    bad            = 1'b0;
    drop           = 1'b0;
    is_send        = 1'b0;
    store_wr.en    = 1'b0;
    store_wr.addr  = swl_pkg::slot_addr(tail_r, stage_r);
    store_wr.data  = in_data_byte;
    elapsed_inc    = (elapsed_r != swl_pkg::ELAPSED_MAX) ? elapsed_r + 16'd1 : elapsed_r;
    if (accept) begin
      unique case (cmd)
        swl_pkg::CMD_ENQUEUE: begin
          if (full) begin
            stage_drop_nxt = 1'b1;
          end else begin
            store_wr.en = 1'b1;
          end
          if (stage_r == swl_pkg::LAST_BYTE) begin
            if (stage_drop_r || full) begin
              drop = 1'b1;
            end else begin
              tail_nxt = swl_pkg::next_slot(tail_r);
              fill_nxt = fill_r + swl_pkg::FILL_W'(1);
            end
            stage_nxt      = '0;
            stage_drop_nxt = 1'b0;
          end else begin
            stage_nxt = stage_r + swl_pkg::BIDX_W'(1);
          end
        end
        swl_pkg::CMD_RX_BYTE: begin
          if (rx_count_r == '0) rx_first_nxt = in_data_byte;
          if (rx_count_r == swl_pkg::BIDX_W'(1)) rx_second_nxt = in_data_byte;
          if (rx_count_r == swl_pkg::LAST_BYTE) begin
            if (in_data_byte != rx_sum_r) begin
              bad = 1'b1;
            end else if (rx_first_r == device_id_r && rx_second_r == status_ok_r) begin
              waiting_nxt   = 1'b0;
              connected_nxt = 1'b1;
            end
            rx_count_nxt = '0;
            rx_sum_nxt   = '0;
          end else begin
            rx_sum_nxt   = rx_sum_r + in_data_byte;
            rx_count_nxt = rx_count_r + swl_pkg::BIDX_W'(1);
          end
        end
        swl_pkg::CMD_TICK: begin
          if (waiting_r) begin
            elapsed_nxt = elapsed_inc;
            if (elapsed_inc >= timeout_r) begin
              waiting_nxt   = 1'b0;
              connected_nxt = 1'b0;
            end
          end
          if (!waiting_nxt && in_tx_ready && fill_r != '0) begin
            head_nxt    = swl_pkg::next_slot(head_r);
            fill_nxt    = fill_r - swl_pkg::FILL_W'(1);
            waiting_nxt = 1'b1;
            elapsed_nxt = '0;
            is_send     = 1'b1;
          end
        end
        swl_pkg::CMD_CLEAR: begin
          head_nxt       = '0;
          tail_nxt       = '0;
          fill_nxt       = '0;
          stage_nxt      = '0;
          stage_drop_nxt = 1'b0;
          waiting_nxt    = 1'b0;
          connected_nxt  = 1'b0;
          elapsed_nxt    = '0;
          rx_count_nxt   = '0;
          rx_sum_nxt     = '0;
          rx_first_nxt   = '0;
          rx_second_nxt  = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    job_push      = accept;
    job.is_send   = is_send;
    job.slot      = head_r;
    job.connected = connected_nxt;
    job.pending   = waiting_nxt;
    job.bad       = bad;
    job.drop      = drop;
    job.level     = swl_pkg::LEVEL_W'(fill_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= swl_pkg::TIMEOUT_RESET;
      device_id_r <= '0;
      status_ok_r <= '0;
    end else if (cfg_wr_en) begin
      priority if (cfg_index == swl_pkg::CFG_TIMEOUT) begin
        timeout_r <= cfg_wdata;
      end else if (cfg_index == swl_pkg::CFG_DEVICE_ID) begin
        device_id_r <= cfg_wdata[swl_pkg::BYTE_W-1:0];
      end else if (cfg_index == swl_pkg::CFG_STATUS_OK) begin
        status_ok_r <= cfg_wdata[swl_pkg::BYTE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r       <= '0;
      tail_r       <= '0;
      fill_r       <= '0;
      stage_r      <= '0;
      stage_drop_r <= 1'b0;
      waiting_r    <= 1'b0;
      connected_r  <= 1'b0;
      elapsed_r    <= '0;
      rx_count_r   <= '0;
      rx_sum_r     <= '0;
      rx_first_r   <= '0;
      rx_second_r  <= '0;
    end else begin
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      fill_r       <= fill_nxt;
      stage_r      <= stage_nxt;
      stage_drop_r <= stage_drop_nxt;
      waiting_r    <= waiting_nxt;
      connected_r  <= connected_nxt;
      elapsed_r    <= elapsed_nxt;
      rx_count_r   <= rx_count_nxt;
      rx_sum_r     <= rx_sum_nxt;
      rx_first_r   <= rx_first_nxt;
      rx_second_r  <= rx_second_nxt;
    end
  end

endmodule
`default_nettype wire

### hdl/swl_job_fifo.sv
// Two-entry job queue between front and back end.
`default_nettype none
module swl_job_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire swl_pkg::job_t push_job,
  input  wire logic          pop,
  output logic               full,
  output logic               avail,
  output swl_pkg::job_t      head_job,
  output logic               has_send
);

  swl_pkg::job_t slot_q [2];
  logic          wr_ptr_r, rd_ptr_r;
  logic [1:0]    count_r;
  logic          vld0, vld1;

  assign full     = (count_r == 2'd2);
  assign avail    = (count_r != 2'd0);
  assign head_job = slot_q[rd_ptr_r];
  assign vld0     = full || (count_r == 2'd1 && rd_ptr_r == 1'b0);
  assign vld1     = full || (count_r == 2'd1 && rd_ptr_r == 1'b1);
  assign has_send = (vld0 && slot_q[0].is_send) || (vld1 && slot_q[1].is_send);

  always_ff @(posedge clk) begin
    if (push) begin
      slot_q[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop) rd_ptr_r <= !rd_ptr_r;
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

### hdl/swl_back.sv
// Back end: streams sent packets with checksum and drives the result register.
`default_nettype none
module swl_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       job_avail,
  input  wire swl_pkg::job_t              job_head,
  output logic                            job_pop,
  output logic      [swl_pkg::ADDR_W-1:0] rd_addr,
  input  wire logic [swl_pkg::BYTE_W-1:0] rd_data,
  output logic                            busy_send,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic                            out_tx_valid,
  output logic      [swl_pkg::BYTE_W-1:0] out_tx_byte,
  output logic                            out_tx_last,
  output logic                            out_link_connected,
  output logic                            out_reply_pending,
  output logic                            out_rx_bad_checksum,
  output logic                            out_queue_dropped,
  output logic      [swl_pkg::LEVEL_W-1:0] out_queue_level
);

  swl_pkg::be_state_t          state_r, state_nxt;
  swl_pkg::job_t               cur_r, cur_nxt;
  logic [swl_pkg::BIDX_W-1:0]  idx_r, idx_nxt;
  logic                        fetched_r, fetched_nxt;
  logic [swl_pkg::BYTE_W-1:0]  sum_r, sum_nxt;
  logic                        can_load, load, at_last;

  logic                        ld_tx_valid, ld_tx_last, ld_conn, ld_pend, ld_bad, ld_drop;
  logic [swl_pkg::BYTE_W-1:0]  ld_byte;
  logic [swl_pkg::LEVEL_W-1:0] ld_level;

  logic                        out_valid_r, tx_valid_r, tx_last_r, conn_r, pend_r;
  logic                        bad_r, drop_r;
  logic [swl_pkg::BYTE_W-1:0]  byte_r;
  logic [swl_pkg::LEVEL_W-1:0] level_r;

  assign can_load  = !out_valid_r || out_ready;
  assign at_last   = (idx_r == swl_pkg::LAST_BYTE);
  assign busy_send = (state_r == swl_pkg::BE_SEND);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      swl_pkg::BE_IDLE: begin
        if (job_avail && job_head.is_send) state_nxt = swl_pkg::BE_SEND;
      end
      swl_pkg::BE_SEND: begin
        if (fetched_r && can_load && at_last) state_nxt = swl_pkg::BE_IDLE;
      end
      default: state_nxt = swl_pkg::BE_IDLE;
    endcase
  end

  always_comb begin
    job_pop     = 1'b0;
    load        = 1'b0;
    cur_nxt     = cur_r;
    idx_nxt     = idx_r;
    fetched_nxt = fetched_r;
    sum_nxt     = sum_r;
    rd_addr     = swl_pkg::slot_addr(cur_r.slot, idx_r);
    ld_tx_valid = 1'b0;
    ld_byte     = '0;
    ld_tx_last  = 1'b1;
    ld_conn     = job_head.connected;
    ld_pend     = job_head.pending;
    ld_bad      = job_head.bad;
    ld_drop     = job_head.drop;
    ld_level    = job_head.level;
    unique case (state_r)
      swl_pkg::BE_IDLE: begin
        if (job_avail) begin
          if (job_head.is_send) begin
            job_pop     = 1'b1;
            cur_nxt     = job_head;
            idx_nxt     = '0;
            fetched_nxt = 1'b0;
            sum_nxt     = '0;
          end else if (can_load) begin
            job_pop = 1'b1;
            load    = 1'b1;
          end
        end
      end
      swl_pkg::BE_SEND: begin
        fetched_nxt = 1'b1;
        ld_tx_valid = 1'b1;
        ld_tx_last  = at_last;
        ld_byte     = at_last ? sum_r : rd_data;
        ld_conn     = cur_r.connected;
        ld_pend     = cur_r.pending;
        ld_bad      = 1'b0;
        ld_drop     = 1'b0;
        ld_level    = cur_r.level;
        if (fetched_r && can_load) begin
          load = 1'b1;
          if (!at_last) begin
            sum_nxt = sum_r + rd_data;
            idx_nxt = idx_r + swl_pkg::BIDX_W'(1);
            rd_addr = swl_pkg::slot_addr(cur_r.slot, idx_r + swl_pkg::BIDX_W'(1));
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    idx_r <= idx_nxt;
    sum_r <= sum_nxt;
    if (load) begin
      tx_valid_r <= ld_tx_valid;
      byte_r     <= ld_byte;
      tx_last_r  <= ld_tx_last;
      conn_r     <= ld_conn;
      pend_r     <= ld_pend;
      bad_r      <= ld_bad;
      drop_r     <= ld_drop;
      level_r    <= ld_level;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= swl_pkg::BE_IDLE;
      fetched_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fetched_r <= fetched_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_tx_valid        = tx_valid_r;
  assign out_tx_byte         = byte_r;
  assign out_tx_last         = tx_last_r;
  assign out_link_connected  = conn_r;
  assign out_reply_pending   = pend_r;
  assign out_rx_bad_checksum = bad_r;
  assign out_queue_dropped   = drop_r;
  assign out_queue_level     = level_r;

endmodule
`default_nettype wire

### tb/tb.sv
// Self-checking testbench for the stop-and-wait packet link top level.
`timescale 1ns / 100ps
module tb;

  localparam int STALL_LIMIT = 2000;
  localparam logic [swl_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic                        tx_valid;
    logic [swl_pkg::BYTE_W-1:0]  tx_byte;
    logic                        tx_last;
    logic                        connected;
    logic                        pending;
    logic                        bad;
    logic                        drop;
    logic [swl_pkg::LEVEL_W-1:0] level;
  } link_rec_t;

  typedef struct {
    swl_pkg::cmd_t              cmd;
    logic [swl_pkg::BYTE_W-1:0] data;
    logic                       rdy;
    int                         reps;
    bit                         typed;
    link_rec_t                  rec;
  } dir_row_t;

  localparam link_rec_t REC_QUIET = '{tx_valid: 1'b0, tx_byte: 8'h00, tx_last: 1'b1,
                                      connected: 1'b0, pending: 1'b0, bad: 1'b0,
                                      drop: 1'b0, level: 4'd0};
  localparam link_rec_t REC_BAD   = '{tx_valid: 1'b0, tx_byte: 8'h00, tx_last: 1'b1,
                                      connected: 1'b0, pending: 1'b0, bad: 1'b1,
                                      drop: 1'b0, level: 4'd0};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_command = swl_pkg::CMD_ENQUEUE;
  logic [swl_pkg::BYTE_W-1:0] in_data_byte = '0;
  logic in_tx_ready = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_tx_valid;
  logic [swl_pkg::BYTE_W-1:0] out_tx_byte;
  logic out_tx_last;
  logic out_link_connected;
  logic out_reply_pending;
  logic out_rx_bad_checksum;
  logic out_queue_dropped;
  logic [swl_pkg::LEVEL_W-1:0] out_queue_level;
  logic cfg_wr_en = 1'b0;
  logic [swl_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [swl_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  always #5 clk = ~clk;

  stop_and_wait_packet_link_top u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_command          (in_command),
    .in_data_byte        (in_data_byte),
    .in_tx_ready         (in_tx_ready),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_tx_valid        (out_tx_valid),
    .out_tx_byte         (out_tx_byte),
    .out_tx_last         (out_tx_last),
    .out_link_connected  (out_link_connected),
    .out_reply_pending   (out_reply_pending),
    .out_rx_bad_checksum (out_rx_bad_checksum),
    .out_queue_dropped   (out_queue_dropped),
    .out_queue_level     (out_queue_level),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  // link state mirror
  logic [swl_pkg::BYTE_W-1:0]    pkt_mem [swl_pkg::STORE_DEPTH];
  logic [swl_pkg::SLOT_W-1:0]    q_head, q_tail;
  logic [swl_pkg::FILL_W-1:0]    q_fill;
  logic [swl_pkg::BIDX_W-1:0]    stage_cnt, rx_cnt;
  logic                          stage_drop, waiting, connected;
  logic [swl_pkg::TIMEOUT_W-1:0] elapsed;
  logic [swl_pkg::BYTE_W-1:0]    rx_sum, rx_b0, rx_b1;
  logic [swl_pkg::TIMEOUT_W-1:0] cfg_timeout;
  logic [swl_pkg::BYTE_W-1:0]    cfg_dev, cfg_ok;

  link_rec_t link_recs_due[$];
  link_rec_t step_recs[$];
  dir_row_t  dir_tab[$];

  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int mismatches = 0;
  int n_req = 0, n_rec = 0, n_sends = 0, n_drops = 0, n_bad = 0, n_ok = 0;
  int stall_cycles = 0;

  function automatic void clear_link_state();
    q_head = '0;
    q_tail = '0;
    q_fill = '0;
    stage_cnt = '0;
    stage_drop = 1'b0;
    waiting = 1'b0;
    connected = 1'b0;
    elapsed = '0;
    rx_cnt = '0;
    rx_sum = '0;
    rx_b0 = '0;
    rx_b1 = '0;
  endfunction

  function automatic void predict_link_step(input swl_pkg::cmd_t cmd,
                                            input logic [swl_pkg::BYTE_W-1:0] b,
                                            input logic rdy);
    logic bad;
    logic drop;
    logic [swl_pkg::BYTE_W-1:0] csum;
    int base;
    link_rec_t r;
    step_recs.delete();
    bad = 1'b0;
    drop = 1'b0;
    case (cmd)
      swl_pkg::CMD_ENQUEUE: begin
        if (q_fill >= swl_pkg::FILL_FULL) stage_drop = 1'b1;
        else pkt_mem[int'(q_tail) * swl_pkg::PACKET_BYTES + int'(stage_cnt)] = b;
        if (stage_cnt == swl_pkg::LAST_BYTE) begin
          if (stage_drop) begin
            drop = 1'b1;
            n_drops++;
          end else begin
            q_tail = (int'(q_tail) == swl_pkg::QUEUE_DEPTH - 1) ? '0 :
                     q_tail + swl_pkg::SLOT_W'(1);
            q_fill = q_fill + swl_pkg::FILL_W'(1);
          end
          stage_cnt = '0;
          stage_drop = 1'b0;
        end else begin
          stage_cnt = stage_cnt + swl_pkg::BIDX_W'(1);
        end
      end
      swl_pkg::CMD_RX_BYTE: begin
        if (rx_cnt == '0) rx_b0 = b;
        if (rx_cnt == swl_pkg::BIDX_W'(1)) rx_b1 = b;
        if (rx_cnt == swl_pkg::LAST_BYTE) begin
          if (b != rx_sum) begin
            bad = 1'b1;
            n_bad++;
          end else if (rx_b0 == cfg_dev && rx_b1 == cfg_ok) begin
            waiting = 1'b0;
            connected = 1'b1;
            n_ok++;
          end
          rx_cnt = '0;
          rx_sum = '0;
        end else begin
          rx_sum = rx_sum + b;
          rx_cnt = rx_cnt + swl_pkg::BIDX_W'(1);
        end
      end
      swl_pkg::CMD_TICK: begin
        if (waiting) begin
          if (elapsed != swl_pkg::ELAPSED_MAX) elapsed = elapsed + swl_pkg::TIMEOUT_W'(1);
          if (elapsed >= cfg_timeout) begin
            waiting = 1'b0;
            connected = 1'b0;
          end
        end
        if (!waiting && rdy && q_fill != '0) begin
          base = int'(q_head) * swl_pkg::PACKET_BYTES;
          csum = '0;
          for (int i = 0; i < swl_pkg::PACKET_BYTES - 1; i++) csum = csum + pkt_mem[base + i];
          pkt_mem[base + swl_pkg::PACKET_BYTES - 1] = csum;
          q_head = (int'(q_head) == swl_pkg::QUEUE_DEPTH - 1) ? '0 :
                   q_head + swl_pkg::SLOT_W'(1);
          q_fill = q_fill - swl_pkg::FILL_W'(1);
          waiting = 1'b1;
          elapsed = '0;
          n_sends++;
          for (int i = 0; i < swl_pkg::PACKET_BYTES; i++) begin
            r = '{1'b1, pkt_mem[base + i], i == swl_pkg::PACKET_BYTES - 1, connected,
                  waiting, 1'b0, 1'b0, swl_pkg::LEVEL_W'(q_fill)};
            step_recs = {step_recs, r};
          end
          return;
        end
      end
      default: clear_link_state();
    endcase
    r = '{1'b0, 8'h00, 1'b1, connected, waiting, bad, drop, swl_pkg::LEVEL_W'(q_fill)};
    step_recs = {step_recs, r};
  endfunction

  // one request on the input channel; the caller lowers in_valid when it stops
  task automatic issue(input swl_pkg::cmd_t cmd, input logic [swl_pkg::BYTE_W-1:0] b,
                       input logic rdy, input bit typed, input link_rec_t trec);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_data_byte <= b;
    in_tx_ready <= rdy;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_req++;
    predict_link_step(cmd, b, rdy);
    if (typed) link_recs_due = {link_recs_due, trec};
    else link_recs_due = {link_recs_due, step_recs};
  endtask

  task automatic configure(input logic [swl_pkg::TIMEOUT_W-1:0] tmo,
                           input logic [swl_pkg::BYTE_W-1:0] dev,
                           input logic [swl_pkg::BYTE_W-1:0] ok);
    in_valid <= 1'b0;
    while (link_recs_due.size() != 0) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= swl_pkg::CFG_TIMEOUT;
    cfg_wdata <= tmo;
    @(posedge clk);
    cfg_index <= swl_pkg::CFG_DEVICE_ID;
    cfg_wdata <= {8'h00, dev};
    @(posedge clk);
    cfg_index <= swl_pkg::CFG_STATUS_OK;
    cfg_wdata <= {8'h00, ok};
    @(posedge clk);
    cfg_index <= CFG_SPARE;
    cfg_wdata <= swl_pkg::CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cfg_timeout = tmo;
    cfg_dev = dev;
    cfg_ok = ok;
  endtask

  task automatic add_row(input swl_pkg::cmd_t cmd, input logic [swl_pkg::BYTE_W-1:0] data,
                         input logic rdy, input int reps, input bit typed,
                         input link_rec_t rec);
    dir_row_t row;
    row.cmd = cmd;
    row.data = data;
    row.rdy = rdy;
    row.reps = reps;
    row.typed = typed;
    row.rec = rec;
    dir_tab = {dir_tab, row};
  endtask

  task automatic enqueue_packet();
    for (int k = 0; k < swl_pkg::PACKET_BYTES; k++)
      issue(swl_pkg::CMD_ENQUEUE, swl_pkg::BYTE_W'($urandom), 1'($urandom), 1'b0,
            REC_QUIET);
  endtask

  task automatic run_traffic(input int n_items);
    int done;
    int r;
    int n_ticks;
    logic [swl_pkg::BYTE_W-1:0] pkt [swl_pkg::PACKET_BYTES];
    logic [swl_pkg::BYTE_W-1:0] s;
    done = 0;
    while (done < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        enqueue_packet();
        done += swl_pkg::PACKET_BYTES;
      end else if (r < 55) begin
        n_ticks = $urandom_range(1, 3);
        repeat (n_ticks)
          issue(swl_pkg::CMD_TICK, swl_pkg::BYTE_W'($urandom), $urandom_range(0, 3) != 0,
                1'b0, REC_QUIET);
        done += n_ticks;
      end else if (r < 80) begin
        // reply: mostly addressed and OK, sometimes off, sometimes corrupted
        pkt[0] = ($urandom_range(0, 3) != 0) ? cfg_dev : swl_pkg::BYTE_W'($urandom);
        pkt[1] = ($urandom_range(0, 3) != 0) ? cfg_ok : swl_pkg::BYTE_W'($urandom);
        for (int k = 2; k < swl_pkg::PACKET_BYTES - 1; k++)
          pkt[k] = swl_pkg::BYTE_W'($urandom);
        s = '0;
        for (int k = 0; k < swl_pkg::PACKET_BYTES - 1; k++) s = s + pkt[k];
        pkt[swl_pkg::PACKET_BYTES - 1] = ($urandom_range(0, 4) != 0) ? s :
                                         s + swl_pkg::BYTE_W'($urandom_range(1, 255));
        for (int k = 0; k < swl_pkg::PACKET_BYTES; k++)
          issue(swl_pkg::CMD_RX_BYTE, pkt[k], 1'($urandom), 1'b0, REC_QUIET);
        done += swl_pkg::PACKET_BYTES;
      end else if (r < 96) begin
        issue(swl_pkg::cmd_t'($urandom_range(0, 2)), swl_pkg::BYTE_W'($urandom),
              1'($urandom), 1'b0, REC_QUIET);
        done++;
      end else begin
        issue(swl_pkg::CMD_CLEAR, swl_pkg::BYTE_W'($urandom), 1'($urandom), 1'b0,
              REC_QUIET);
        done++;
      end
    end
  endtask

  always @(posedge clk) begin : result_check
    link_rec_t got;
    link_rec_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got = {out_tx_valid, out_tx_byte, out_tx_last, out_link_connected,
               out_reply_pending, out_rx_bad_checksum, out_queue_dropped, out_queue_level};
        n_rec++;
        if (link_recs_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result valid=%0b byte=%02h last=%0b", $realtime,
                     got.tx_valid, got.tx_byte, got.tx_last);
        end else begin
          want = link_recs_due.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: result %0d exp v=%0b b=%02h l=%0b c=%0b p=%0b bad=%0b drop=%0b lvl=%0d",
                       $realtime, n_rec, want.tx_valid, want.tx_byte, want.tx_last,
                       want.connected, want.pending, want.bad, want.drop, want.level);
              $display("    got v=%0b b=%02h l=%0b c=%0b p=%0b bad=%0b drop=%0b lvl=%0d",
                       got.tx_valid, got.tx_byte, got.tx_last, got.connected, got.pending,
                       got.bad, got.drop, got.level);
            end
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
               stall_cycles, link_recs_due.size());
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    clear_link_state();
    cfg_timeout = swl_pkg::TIMEOUT_RESET;
    cfg_dev = '0;
    cfg_ok = '0;

    // directed requests, link set up with timeout 2, device FF, OK code 00
    add_row(swl_pkg::CMD_TICK,    8'hFF, 1'b1, 1,  1'b1, REC_QUIET);
    add_row(swl_pkg::CMD_RX_BYTE, 8'h00, 1'b0, 1,  1'b1, REC_QUIET);
    add_row(swl_pkg::CMD_CLEAR,   8'hFF, 1'b1, 1,  1'b1, REC_QUIET);
    add_row(swl_pkg::CMD_ENQUEUE, 8'hFF, 1'b1, 15, 1'b0, REC_QUIET);
    add_row(swl_pkg::CMD_ENQUEUE, 8'h00, 1'b0, 1,  1'b0, REC_QUIET);
    add_row(swl_pkg::CMD_TICK,    8'h00, 1'b0, 1,  1'b0, REC_QUIET);
    add_row(swl_pkg::CMD_TICK,    8'h00, 1'b1, 1,  1'b0, REC_QUIET);
    add_row(swl_pkg::CMD_TICK,    8'hFF, 1'b1, 2,  1'b0, REC_QUIET);
    // bad checksum reply
    add_row(swl_pkg::CMD_RX_BYTE, 8'hFF, 1'b1, 1,  1'b0, REC_QUIET);
    add_row(swl_pkg::CMD_RX_BYTE, 8'h00, 1'b0, 1,  1'b0, REC_QUIET);
    add_row(swl_pkg::CMD_RX_BYTE, 8'h01, 1'b0, 13, 1'b0, REC_QUIET);
    add_row(swl_pkg::CMD_RX_BYTE, 8'h00, 1'b0, 1,  1'b1, REC_BAD);
    // good OK reply while idle
    add_row(swl_pkg::CMD_RX_BYTE, 8'hFF, 1'b0, 1,  1'b0, REC_QUIET);
    add_row(swl_pkg::CMD_RX_BYTE, 8'h00, 1'b0, 14, 1'b0, REC_QUIET);
    add_row(swl_pkg::CMD_RX_BYTE, 8'hFF, 1'b0, 1,  1'b0, REC_QUIET);
    // send, then a reply ends the wait
    add_row(swl_pkg::CMD_ENQUEUE, 8'h5A, 1'b0, 16, 1'b0, REC_QUIET);
    add_row(swl_pkg::CMD_TICK,    8'h00, 1'b1, 1,  1'b0, REC_QUIET);
    add_row(swl_pkg::CMD_RX_BYTE, 8'hFF, 1'b0, 1,  1'b0, REC_QUIET);
    add_row(swl_pkg::CMD_RX_BYTE, 8'h00, 1'b0, 14, 1'b0, REC_QUIET);
    add_row(swl_pkg::CMD_RX_BYTE, 8'hFF, 1'b0, 1,  1'b0, REC_QUIET);
    // clear drops partial staging and partial receive
    add_row(swl_pkg::CMD_ENQUEUE, 8'h80, 1'b1, 5,  1'b0, REC_QUIET);
    add_row(swl_pkg::CMD_RX_BYTE, 8'h37, 1'b1, 3,  1'b0, REC_QUIET);
    add_row(swl_pkg::CMD_CLEAR,   8'h00, 1'b0, 1,  1'b1, REC_QUIET);
    add_row(swl_pkg::CMD_ENQUEUE, 8'h01, 1'b0, 16, 1'b0, REC_QUIET);
    add_row(swl_pkg::CMD_TICK,    8'h00, 1'b1, 1,  1'b0, REC_QUIET);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    in_idle_pct = 37;
    out_idle_pct = 53;
    configure(16'd2, 8'hFF, 8'h00);
    foreach (dir_tab[i])
      repeat (dir_tab[i].reps)
        issue(dir_tab[i].cmd, dir_tab[i].data, dir_tab[i].rdy, dir_tab[i].typed,
              dir_tab[i].rec);

    configure(16'd0, 8'h00, 8'hFF);
    run_traffic(12);

    in_idle_pct = 53;
    out_idle_pct = 37;
    configure(16'hFFFF, swl_pkg::BYTE_W'($urandom), swl_pkg::BYTE_W'($urandom));
    run_traffic(12);

    in_idle_pct = 0;
    out_idle_pct = 0;
    configure(swl_pkg::TIMEOUT_W'($urandom_range(1, 6)), swl_pkg::BYTE_W'($urandom),
              swl_pkg::BYTE_W'($urandom));
    run_traffic(12);

    in_valid <= 1'b0;
    while (link_recs_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Ran %0d requests and checked %0d result records", n_req, n_rec);
    $display("Packets sent %0d, dropped %0d, bad checksums %0d, OK replies %0d",
             n_sends, n_drops, n_bad, n_ok);
    if (mismatches == 0 && link_recs_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d results never seen", mismatches, link_recs_due.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
